// ===== hdl/tcpq_pkg.sv =====
// Package for the two-class priority queue: field widths, stream layout,
// opcodes, status codes and reset values.
// Depends on nothing.
`default_nettype none

package tcpq_pkg;

    localparam int NORMAL_DEPTH_DEF   = 16;
    localparam int PRIORITY_DEPTH_DEF = 8;

    localparam int TAG_W    = 32;
    localparam int AGE_W    = 8;
    localparam int ENTRY_W  = TAG_W + AGE_W;
    localparam int STATUS_W = 3;
    localparam int NFILL_W  = 5;
    localparam int PFILL_W  = 4;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_RES_W   = TAG_W + AGE_W + NFILL_W + PFILL_W;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = STATUS_W;

    localparam logic [AGE_W-1:0] THRESHOLD_RESET = 8'd60;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_TO_PRIO      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TO_NORMAL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SERVED_PRIO  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SERVED_NORM  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd6;

    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

// ===== hdl/two_class_priority_queue.sv =====
// Top level of the two-class priority queue: two circular FIFOs in
// synchronous memories with strict-priority service.
// Depends on tcpq_pkg.
`default_nettype none

// Each transfer on the input stream is an enqueue or a dequeue and yields
// exactly one result transfer. Entries of age at or above the threshold go
// to the priority FIFO, overflow to the normal FIFO when it is full, and are
// rejected when both are full; younger ones are rejected when the normal
// FIFO is full. A dequeue serves the priority head first. The block takes
// one item per cycle while the output side keeps up. Each result passes
// through the registered FIFO memory read, then the output register. The
// memories need no clearing pass after reset, since only occupied entries
// are ever read. The threshold register may be written only while idle.
module two_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int NORMAL_DEPTH   = NORMAL_DEPTH_DEF,
    parameter int PRIORITY_DEPTH = PRIORITY_DEPTH_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [AGE_W-1:0]     cfg_data,

    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: person_tag[31:0], age[39:32].
    input  wire  [S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: opcode[0].
    input  wire  [S_TUSER_W-1:0] s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // Fields from bit 0: served_tag[31:0], served_age[39:32],
    // normal_fill[44:40], priority_fill[48:45], zero fill above.
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int NAW = $clog2(NORMAL_DEPTH);
    localparam int PAW = $clog2(PRIORITY_DEPTH);
    localparam int NCW = $clog2(NORMAL_DEPTH + 1);
    localparam int PCW = $clog2(PRIORITY_DEPTH + 1);

    entry_t normal_mem [NORMAL_DEPTH];
    entry_t prio_mem   [PRIORITY_DEPTH];

    logic [AGE_W-1:0]    thr_reg;
    logic [NAW-1:0]      n_head_reg, n_head_next;
    logic [NCW-1:0]      n_count_reg, n_count_next;
    logic [PAW-1:0]      p_head_reg, p_head_next;
    logic [PCW-1:0]      p_count_reg, p_count_next;
    entry_t              n_rdata_reg, p_rdata_reg;

    logic                pend_valid_reg, pend_valid_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [NFILL_W-1:0]  pend_nfill_reg, pend_nfill_next;
    logic [PFILL_W-1:0]  pend_pfill_reg, pend_pfill_next;

    logic                out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_tdata_reg;
    logic [M_TUSER_W-1:0] out_tuser_reg;

    logic                s_acc, out_load;
    logic                op;
    entry_t              in_entry;
    logic                n_full, p_full, is_prio;
    logic                n_wr, p_wr, n_rd, p_rd;
    logic [NCW:0]        n_sum, n_wrap;
    logic [PCW:0]        p_sum, p_wrap;
    logic [NAW-1:0]      n_slot, n_head_inc;
    logic [PAW-1:0]      p_slot, p_head_inc;
    logic [NCW+NFILL_W-1:0] n_fill_ext;
    logic [PCW+PFILL_W-1:0] p_fill_ext;
    entry_t              served;
    logic [M_RES_W-1:0]  res;

    assign cfg_ready     = 1'b1;
    assign out_load      = pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_valid_reg || out_load;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign op       = s_axis_tuser[0];
    assign in_entry = {s_axis_tdata[TAG_W+AGE_W-1:TAG_W], s_axis_tdata[TAG_W-1:0]};
    assign n_full   = (n_count_reg == NCW'(NORMAL_DEPTH));
    assign p_full   = (p_count_reg == PCW'(PRIORITY_DEPTH));
    assign is_prio  = (s_axis_tdata[TAG_W+AGE_W-1:TAG_W] >= thr_reg);

    assign n_sum  = (NCW+1)'(n_head_reg) + (NCW+1)'(n_count_reg);
    assign n_wrap = (n_sum >= (NCW+1)'(NORMAL_DEPTH)) ?
                    n_sum - (NCW+1)'(NORMAL_DEPTH) : n_sum;
    assign n_slot = n_wrap[NAW-1:0];
    assign p_sum  = (PCW+1)'(p_head_reg) + (PCW+1)'(p_count_reg);
    assign p_wrap = (p_sum >= (PCW+1)'(PRIORITY_DEPTH)) ?
                    p_sum - (PCW+1)'(PRIORITY_DEPTH) : p_sum;
    assign p_slot = p_wrap[PAW-1:0];

    assign n_head_inc = (n_head_reg == NAW'(NORMAL_DEPTH - 1)) ? '0 : n_head_reg + 1'b1;
    assign p_head_inc = (p_head_reg == PAW'(PRIORITY_DEPTH - 1)) ? '0 : p_head_reg + 1'b1;

    always_comb
    begin
        n_wr             = 1'b0;
        p_wr             = 1'b0;
        n_rd             = 1'b0;
        p_rd             = 1'b0;
        n_head_next      = n_head_reg;
        n_count_next     = n_count_reg;
        p_head_next      = p_head_reg;
        p_count_next     = p_count_reg;
        pend_status_next = ST_EMPTY;
        if (op == OP_ENQUEUE)
        begin
            if (is_prio && !p_full)
            begin
                p_wr             = s_acc;
                p_count_next     = p_count_reg + 1'b1;
                pend_status_next = ST_TO_PRIO;
            end
            else if (!n_full)
            begin
                n_wr             = s_acc;
                n_count_next     = n_count_reg + 1'b1;
                pend_status_next = is_prio ? ST_OVERFLOW : ST_TO_NORMAL;
            end
            else
            begin
                pend_status_next = ST_REJECTED;
            end
        end
        else
        begin
            if (p_count_reg != '0)
            begin
                p_rd             = s_acc;
                p_head_next      = p_head_inc;
                p_count_next     = p_count_reg - 1'b1;
                pend_status_next = ST_SERVED_PRIO;
            end
            else if (n_count_reg != '0)
            begin
                n_rd             = s_acc;
                n_head_next      = n_head_inc;
                n_count_next     = n_count_reg - 1'b1;
                pend_status_next = ST_SERVED_NORM;
            end
            else
            begin
                pend_status_next = ST_EMPTY;
            end
        end
    end

    assign n_fill_ext      = {{NFILL_W{1'b0}}, n_count_next};
    assign p_fill_ext      = {{PFILL_W{1'b0}}, p_count_next};
    assign pend_nfill_next = n_fill_ext[NFILL_W-1:0];
    assign pend_pfill_next = p_fill_ext[PFILL_W-1:0];
    assign pend_valid_next = s_acc ? 1'b1 : (out_load ? 1'b0 : pend_valid_reg);
    assign out_valid_next  = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_comb
    begin
        case (pend_status_reg)
            ST_SERVED_PRIO: served = p_rdata_reg;
            ST_SERVED_NORM: served = n_rdata_reg;
            default:        served = '0;
        endcase
    end

    assign res = {pend_pfill_reg, pend_nfill_reg, served};

    always_ff @(posedge clk)
    begin
        if (n_wr)
        begin
            normal_mem[n_slot] <= in_entry;
        end
        if (n_rd)
        begin
            n_rdata_reg <= normal_mem[n_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_wr)
        begin
            prio_mem[p_slot] <= in_entry;
        end
        if (p_rd)
        begin
            p_rdata_reg <= prio_mem[p_head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THRESHOLD_RESET;
            n_head_reg     <= '0;
            n_count_reg    <= '0;
            p_head_reg     <= '0;
            p_count_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (s_acc)
            begin
                n_head_reg  <= n_head_next;
                n_count_reg <= n_count_next;
                p_head_reg  <= p_head_next;
                p_count_reg <= p_count_next;
            end
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            pend_status_reg <= pend_status_next;
            pend_nfill_reg  <= pend_nfill_next;
            pend_pfill_reg  <= pend_pfill_next;
        end
        if (out_load)
        begin
            out_tdata_reg <= {{(M_TDATA_W-M_RES_W){1'b0}}, res};
            out_tuser_reg <= pend_status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (n_count_reg <= NCW'(NORMAL_DEPTH)) && (p_count_reg <= PCW'(PRIORITY_DEPTH)))
        else $error("FIFO count beyond its depth");

    a_pend_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !out_load) |-> !s_acc)
        else $error("pending result overwritten by a new transfer");

    a_prio_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && op == OP_DEQUEUE && p_count_reg != '0)
        |=> (p_count_reg == $past(p_count_reg) - 1'b1) && (n_count_reg == $past(n_count_reg)))
        else $error("priority dequeue did not take exactly one priority entry");

    a_served_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && pend_status_reg == ST_EMPTY) |=> (m_axis_tdata[ENTRY_W-1:0] == '0))
        else $error("empty dequeue carries a served entry");

endmodule

`default_nettype wire
